// ----- hw/rtl/vidya_pkg.sv -----
// ============================================================================
// vidya_pkg
// Shared widths and constants for the VIDYA adaptive moving average.
// ============================================================================
package vidya_pkg;

    // Price and average format: signed Q16.16.
    localparam int PRICE_BITS   = 32;
    // Window length register and its limits.
    localparam int WIN_BITS     = 9;
    localparam int MAX_WINDOW   = 256;
    localparam int WINDOW_RESET = 14;
    localparam int PTR_BITS     = $clog2(MAX_WINDOW);

    // One price difference and the running sums of rises and falls.
    localparam int DIFF_BITS    = PRICE_BITS + 1;
    localparam int SUM_BITS     = DIFF_BITS + PTR_BITS;

    // Momentum ratio in Q1.30: one integer bit plus thirty fraction bits.
    localparam int CMO_FRAC     = 30;
    localparam int CMO_BITS     = CMO_FRAC + 1;
    localparam int CMO_STEPS    = CMO_BITS;

    // Gain in Q2.24. The gain dividend is (2*cmo + 32*(L+1)) / 64.
    localparam int GAIN_FRAC    = 24;
    localparam int GNUM_SHIFT   = 6;
    localparam int GSUM_BITS    = CMO_BITS + 1;
    localparam int GNUM_BITS    = GSUM_BITS - GNUM_SHIFT;
    localparam int GAIN_STEPS   = GNUM_BITS;

    // Product of the gap magnitude and the gain, then the rounded step.
    localparam int ACC_BITS     = DIFF_BITS + GAIN_FRAC + 1;
    localparam int STEP_BITS    = ACC_BITS - GAIN_FRAC;
    localparam int NEXT_BITS    = STEP_BITS + 1;

    localparam int CNT_BITS     = $clog2(CMO_STEPS);

    localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (GAIN_FRAC - 1);

endpackage

// ----- hw/rtl/vidya_ram.sv -----
// ============================================================================
// vidya_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module vidya_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/vidya_adaptive_average.sv -----
// Sequence: a seeding item goes from its transfer straight to S_DONE; an item with
// no movement in its window passes S_RETIRE, S_ADD, S_PREP, S_ROUND and S_APPLY to
// S_DONE; any other item also runs the 31-step bit-serial momentum divider and the
// 26-step gain divider feeding a bit-serial multiplier. One price is in flight at a time.
// Reset: asynchronous, active low; the window length returns to 14, the sums
// and the window are emptied and the next price seeds the average.
// ============================================================================
// vidya_adaptive_average
// Variable index dynamic average over signed Q16.16 prices, one result per
// price, with the momentum window held in a small ring RAM.
// ============================================================================
module vidya_adaptive_average (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [vidya_pkg::PRICE_BITS-1:0]     close_price,
    input  logic                                 restart,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [vidya_pkg::PRICE_BITS-1:0]     average,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vidya_pkg::WIN_BITS-1:0]       window_length
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RETIRE,
        S_ADD,
        S_PREP,
        S_CMO,
        S_GNUM,
        S_GDIV,
        S_ROUND,
        S_APPLY,
        S_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic                                out_valid_reg, out_valid_next;
    logic [vidya_pkg::PRICE_BITS-1:0]    average_reg, average_next;
    logic [vidya_pkg::WIN_BITS-1:0]      wlen_reg, wlen_next;
    logic [vidya_pkg::PRICE_BITS-1:0]    smoothed_reg, smoothed_next;
    logic [vidya_pkg::PRICE_BITS-1:0]    prev_reg, prev_next;
    logic [vidya_pkg::SUM_BITS-1:0]      rise_reg, rise_next;
    logic [vidya_pkg::SUM_BITS-1:0]      fall_reg, fall_next;
    logic [vidya_pkg::PTR_BITS-1:0]      ptr_reg, ptr_next;
    logic [vidya_pkg::WIN_BITS-1:0]      filled_reg, filled_next;
    logic                                seeded_reg, seeded_next;
    logic [vidya_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;

    logic [vidya_pkg::PRICE_BITS-1:0]    price_reg, price_next;
    logic [vidya_pkg::DIFF_BITS-1:0]     diff_reg, diff_next;
    logic [vidya_pkg::SUM_BITS-1:0]      den_reg, den_next;
    logic [vidya_pkg::SUM_BITS-1:0]      rem_reg, rem_next;
    logic [vidya_pkg::CMO_BITS-1:0]      quo_reg, quo_next;
    logic [vidya_pkg::GNUM_BITS-1:0]     gnum_reg, gnum_next;
    logic [vidya_pkg::WIN_BITS-1:0]      grem_reg, grem_next;
    logic [vidya_pkg::ACC_BITS-1:0]      acc_reg, acc_next;
    logic [vidya_pkg::DIFF_BITS-1:0]     mag_reg, mag_next;
    logic                                gap_neg_reg, gap_neg_next;

    logic [vidya_pkg::DIFF_BITS-1:0]     ring_rd_data;
    logic                                ring_wr_en;
    logic                                in_xfer;
    logic                                cfg_xfer;

    logic [vidya_pkg::WIN_BITS-1:0]      len_w;
    logic [vidya_pkg::WIN_BITS-1:0]      len_p1;
    logic [vidya_pkg::DIFF_BITS-1:0]     diff_w;
    logic [vidya_pkg::DIFF_BITS-1:0]     old_mag;
    logic [vidya_pkg::DIFF_BITS-1:0]     new_mag;
    logic [vidya_pkg::WIN_BITS-1:0]      ptr_inc;
    logic [vidya_pkg::SUM_BITS-1:0]      total_w;
    logic [vidya_pkg::SUM_BITS-1:0]      spread_w;
    logic [vidya_pkg::DIFF_BITS-1:0]     gap_w;
    logic [vidya_pkg::SUM_BITS:0]        cand_w;
    logic                                cmo_ge;
    logic [vidya_pkg::GSUM_BITS-1:0]     gsum_w;
    logic [vidya_pkg::WIN_BITS:0]        gcand_w;
    logic                                gain_ge;
    logic [vidya_pkg::NEXT_BITS-1:0]     nv_w;
    logic [vidya_pkg::PRICE_BITS-1:0]    sat_w;

    vidya_ram #(
        .WIDTH (vidya_pkg::DIFF_BITS),
        .DEPTH (vidya_pkg::MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (diff_w),
        .rd_en   (in_xfer),
        .rd_addr (ptr_reg),
        .rd_data (ring_rd_data)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign ring_wr_en = (state_reg == S_RETIRE);

    // Window length 0 acts as 1 and anything past the ring depth as the depth.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_w = vidya_pkg::WIN_BITS'(1);
        end
        else if (wlen_reg > vidya_pkg::WIN_BITS'(vidya_pkg::MAX_WINDOW))
        begin
            len_w = vidya_pkg::WIN_BITS'(vidya_pkg::MAX_WINDOW);
        end
        else
        begin
            len_w = wlen_reg;
        end
    end

    assign len_p1  = len_w + vidya_pkg::WIN_BITS'(1);
    assign diff_w  = {price_reg[vidya_pkg::PRICE_BITS-1], price_reg}
                   - {prev_reg[vidya_pkg::PRICE_BITS-1], prev_reg};
    assign old_mag = ring_rd_data[vidya_pkg::DIFF_BITS-1] ? (~ring_rd_data + 1'b1)
                                                           : ring_rd_data;
    assign new_mag = diff_reg[vidya_pkg::DIFF_BITS-1] ? (~diff_reg + 1'b1) : diff_reg;
    assign ptr_inc = vidya_pkg::WIN_BITS'(ptr_reg) + vidya_pkg::WIN_BITS'(1);
    assign total_w = rise_reg + fall_reg;
    assign spread_w = (rise_reg >= fall_reg) ? (rise_reg - fall_reg) : (fall_reg - rise_reg);
    assign gap_w   = {price_reg[vidya_pkg::PRICE_BITS-1], price_reg}
                   - {smoothed_reg[vidya_pkg::PRICE_BITS-1], smoothed_reg};

    // The first momentum step compares the spread itself; later steps double it.
    assign cand_w  = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign cmo_ge  = (cand_w >= {1'b0, den_reg});
    assign gsum_w  = {quo_reg, 1'b0}
                   + vidya_pkg::GSUM_BITS'({len_p1, 5'b0});
    assign gcand_w = {grem_reg, gnum_reg[vidya_pkg::GNUM_BITS-1]};
    assign gain_ge = (gcand_w >= {1'b0, len_p1});

    assign nv_w = gap_neg_reg
        ? ({{(vidya_pkg::NEXT_BITS-vidya_pkg::PRICE_BITS){smoothed_reg[vidya_pkg::PRICE_BITS-1]}},
            smoothed_reg} - vidya_pkg::NEXT_BITS'(acc_reg[vidya_pkg::STEP_BITS-1:0]))
        : ({{(vidya_pkg::NEXT_BITS-vidya_pkg::PRICE_BITS){smoothed_reg[vidya_pkg::PRICE_BITS-1]}},
            smoothed_reg} + vidya_pkg::NEXT_BITS'(acc_reg[vidya_pkg::STEP_BITS-1:0]));

    // The new average saturates when the bits from the price sign bit up to its
    // own sign bit do not all agree.
    always_comb
    begin
        if (!nv_w[vidya_pkg::NEXT_BITS-1]
            && (nv_w[vidya_pkg::NEXT_BITS-2:vidya_pkg::PRICE_BITS-1] != '0))
        begin
            sat_w = {1'b0, {(vidya_pkg::PRICE_BITS-1){1'b1}}};
        end
        else if (nv_w[vidya_pkg::NEXT_BITS-1]
                 && (nv_w[vidya_pkg::NEXT_BITS-2:vidya_pkg::PRICE_BITS-1] != '1))
        begin
            sat_w = {1'b1, {(vidya_pkg::PRICE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_w = nv_w[vidya_pkg::PRICE_BITS-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;
        wlen_next      = wlen_reg;
        smoothed_next  = smoothed_reg;
        prev_next      = prev_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        ptr_next       = ptr_reg;
        filled_next    = filled_reg;
        seeded_next    = seeded_reg;
        cnt_next       = cnt_reg;
        price_next     = price_reg;
        diff_next      = diff_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        gnum_next      = gnum_reg;
        grem_next      = grem_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        gap_neg_next   = gap_neg_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_xfer)
                begin
                    wlen_next   = window_length;
                    rise_next   = '0;
                    fall_next   = '0;
                    ptr_next    = '0;
                    filled_next = '0;
                end
                else if (in_xfer)
                begin
                    price_next = close_price;
                    if (restart || !seeded_reg)
                    begin
                        smoothed_next = close_price;
                        prev_next     = close_price;
                        rise_next     = '0;
                        fall_next     = '0;
                        ptr_next      = '0;
                        filled_next   = '0;
                        seeded_next   = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RETIRE;
                    end
                end
            end

            // The oldest difference leaves the sums once the window is full;
            // the new one takes its place in the ring.
            S_RETIRE:
            begin
                diff_next = diff_w;
                if (filled_reg >= len_w)
                begin
                    if (!ring_rd_data[vidya_pkg::DIFF_BITS-1] && (ring_rd_data != '0))
                    begin
                        rise_next = rise_reg - vidya_pkg::SUM_BITS'(old_mag);
                    end
                    else
                    begin
                        fall_next = fall_reg - vidya_pkg::SUM_BITS'(old_mag);
                    end
                end
                state_next = S_ADD;
            end

            S_ADD:
            begin
                if (!diff_reg[vidya_pkg::DIFF_BITS-1] && (diff_reg != '0))
                begin
                    rise_next = rise_reg + vidya_pkg::SUM_BITS'(new_mag);
                end
                else
                begin
                    fall_next = fall_reg + vidya_pkg::SUM_BITS'(new_mag);
                end
                ptr_next = (ptr_inc >= len_w) ? '0 : ptr_inc[vidya_pkg::PTR_BITS-1:0];
                if (filled_reg < len_w)
                begin
                    filled_next = filled_reg + vidya_pkg::WIN_BITS'(1);
                end
                prev_next  = price_reg;
                state_next = S_PREP;
            end

            S_PREP:
            begin
                den_next     = total_w;
                rem_next     = spread_w;
                quo_next     = '0;
                cnt_next     = '0;
                gap_neg_next = gap_w[vidya_pkg::DIFF_BITS-1];
                mag_next     = gap_w[vidya_pkg::DIFF_BITS-1] ? (~gap_w + 1'b1) : gap_w;
                if (total_w == '0)
                begin
                    acc_next   = '0;
                    state_next = S_ROUND;
                end
                else
                begin
                    state_next = S_CMO;
                end
            end

            S_CMO:
            begin
                rem_next = cmo_ge ? vidya_pkg::SUM_BITS'(cand_w - {1'b0, den_reg})
                                  : vidya_pkg::SUM_BITS'(cand_w);
                quo_next = {quo_reg[vidya_pkg::CMO_BITS-2:0], cmo_ge};
                cnt_next = cnt_reg + vidya_pkg::CNT_BITS'(1);
                if (cnt_reg == vidya_pkg::CNT_BITS'(vidya_pkg::CMO_STEPS - 1))
                begin
                    state_next = S_GNUM;
                end
            end

            S_GNUM:
            begin
                gnum_next  = gsum_w[vidya_pkg::GSUM_BITS-1:vidya_pkg::GNUM_SHIFT];
                grem_next  = '0;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_GDIV;
            end

            // Gain bits come out of the divider MSB first and go straight
            // into a shift-and-add product with the gap magnitude.
            S_GDIV:
            begin
                grem_next = gain_ge ? vidya_pkg::WIN_BITS'(gcand_w - {1'b0, len_p1})
                                    : gcand_w[vidya_pkg::WIN_BITS-1:0];
                gnum_next = {gnum_reg[vidya_pkg::GNUM_BITS-2:0], 1'b0};
                acc_next  = {acc_reg[vidya_pkg::ACC_BITS-2:0], 1'b0}
                          + (gain_ge ? vidya_pkg::ACC_BITS'(mag_reg) : '0);
                cnt_next  = cnt_reg + vidya_pkg::CNT_BITS'(1);
                if (cnt_reg == vidya_pkg::CNT_BITS'(vidya_pkg::GAIN_STEPS - 1))
                begin
                    state_next = S_ROUND;
                end
            end

            S_ROUND:
            begin
                acc_next   = (acc_reg + vidya_pkg::ROUND_HALF) >> vidya_pkg::GAIN_FRAC;
                state_next = S_APPLY;
            end

            S_APPLY:
            begin
                smoothed_next = sat_w;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    average_next   = smoothed_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            wlen_reg      <= vidya_pkg::WIN_BITS'(vidya_pkg::WINDOW_RESET);
            smoothed_reg  <= '0;
            prev_reg      <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            ptr_reg       <= '0;
            filled_reg    <= '0;
            seeded_reg    <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wlen_reg      <= wlen_next;
            smoothed_reg  <= smoothed_next;
            prev_reg      <= prev_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            ptr_reg       <= ptr_next;
            filled_reg    <= filled_next;
            seeded_reg    <= seeded_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        average_reg <= average_next;
        price_reg   <= price_next;
        diff_reg    <= diff_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        gnum_reg    <= gnum_next;
        grem_reg    <= grem_next;
        acc_reg     <= acc_next;
        mag_reg     <= mag_next;
        gap_neg_reg <= gap_neg_next;
    end

endmodule

// ----- hw/rtl/vidya_checker.sv -----
// ============================================================================
// vidya_checker
// Port-level checks on the VIDYA block, attached to the top level by bind.
// ============================================================================
module vidya_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [vidya_pkg::PRICE_BITS-1:0] average,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready
);

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average))
        else $error("average changed while stalled");

    // One item at a time: after an input transfer the input side closes.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // A configuration write and an input transfer never share a cycle.
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && cfg_valid && cfg_ready))
        else $error("configuration and input transferred together");

    // No result appears in the cycle right after an input transfer.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised too early");

endmodule

bind vidya_adaptive_average vidya_checker u_vidya_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .average   (average),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
